### rtl/gcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, point codes, register indexes and the side-stage record
// used by the grid cell contour pipeline.
// ----------------------------------------------------------------------------
package gcc_pkg;

   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int DIV_STEPS  = DATA_W;
   localparam int LANES      = 4;
   localparam int LINE_SLOTS = 16;
   localparam int POLY_SLOTS = 5;
   localparam int SLOTS      = LINE_SLOTS + POLY_SLOTS;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CSR_IDX_W  = 2;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_ISO_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEXT_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_ENABLE = 2'd3;

   // side lanes of the interpolation pipe
   localparam int SIDE_L = 0;
   localparam int SIDE_R = 1;
   localparam int SIDE_U = 2;
   localparam int SIDE_D = 3;

   // cell points: four corners and the four side crossings
   typedef enum logic [2:0] {
      PT_TL = 3'd0,
      PT_TR = 3'd1,
      PT_BR = 3'd2,
      PT_BL = 3'd3,
      PT_L  = 3'd4,
      PT_R  = 3'd5,
      PT_U  = 3'd6,
      PT_D  = 3'd7
   } pt_id_type;

   // fixed order of the contour line candidates
   localparam pt_id_type LINE_PT [LINE_SLOTS] = '{
      PT_L, PT_TL, PT_BL, PT_R, PT_TR, PT_BR, PT_U, PT_TL,
      PT_TR, PT_D, PT_BL, PT_BR, PT_TL, PT_BR, PT_TR, PT_BL
   };

   // per-cell record carried alongside the divider lanes
   // corner order: 0 top left, 1 bottom left, 2 bottom right, 3 top right
   typedef struct packed {
      logic [3:0]        lt;
      logic [3:0]        eq;
      logic [3:0]        gt;
      logic              all_ge_next;
      logic              fill;
      logic              band;
      logic [LANES-1:0]  up_dir;
      logic [DATA_W-1:0] col_lo;
      logic [DATA_W-1:0] col_hi;
      logic [DATA_W-1:0] row_lo;
      logic [DATA_W-1:0] row_hi;
   } cell_tag_type;

endpackage
`default_nettype wire

### rtl/grid_cell_contour_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_contour_top
// Contour line and fill polygon points for one grid cell per request.
// ----------------------------------------------------------------------------
// A request (four corner values and the cell edge coordinates) is taken on
// a clock edge with start high and busy low. Points come out one per cycle
// on the rsp_ ports, marked by rsp_valid for exactly one cycle: line points
// first, then polygon points; rsp_shape_end flags the last point of each
// shape and rsp_cell_end the last point of the cell. A cell may produce no
// points at all.
// The first point of a request passes the input register, difference stage,
// multiply stage, 32 divider stages and output register. Throughput: one
// cell per cycle while cells produce at most one point; a cell with more
// points holds the next cell back until its last point is sent, since the
// output register sends one point a cycle. busy stalls the stages before it
// while a cell waits at the divider and more than one point is pending.
// The csr_ port writes iso_level, next_level, fill_enable and band_enable;
// it is always ready. Synchronous reset clears control registers and valid
// bits and drops every request in flight. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module grid_cell_contour_top
   import gcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic signed [31:0]   req_z_top_left,
   input  wire logic signed [31:0]   req_z_bottom_left,
   input  wire logic signed [31:0]   req_z_bottom_right,
   input  wire logic signed [31:0]   req_z_top_right,
   input  wire logic signed [31:0]   req_col_lo,
   input  wire logic signed [31:0]   req_col_hi,
   input  wire logic signed [31:0]   req_row_lo,
   input  wire logic signed [31:0]   req_row_hi,
   output logic                      rsp_valid,
   output logic                      rsp_shape_kind,
   output logic signed [31:0]        rsp_point_col,
   output logic signed [31:0]        rsp_point_row,
   output logic                      rsp_shape_end,
   output logic                      rsp_cell_end,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   function automatic logic [DATA_W-1:0] abs_diff(input logic signed [DATA_W-1:0] a,
                                                  input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0] dif;
      logic [DATA_W:0] mag;
      dif = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      mag = dif[DATA_W] ? ({(DATA_W+1){1'b0}} - dif) : dif;
      return mag[DATA_W-1:0];
   endfunction

   // control registers
   logic signed [DATA_W-1:0] iso_ff, next_ff;
   logic                     fill_ff, band_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff  <= '0;
         next_ff <= '0;
         fill_ff <= 1'b0;
         band_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ISO_LEVEL:   iso_ff  <= csr_wdata;
            CSR_NEXT_LEVEL:  next_ff <= csr_wdata;
            CSR_FILL_ENABLE: fill_ff <= csr_wdata[0];
            CSR_BAND_ENABLE: band_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic en;
   logic stall;
   assign en   = !stall;
   assign busy = stall;

   // input register
   logic                     p0_vld_ff;
   logic signed [DATA_W-1:0] p0_z_ff [4];
   logic signed [DATA_W-1:0] p0_cl_ff, p0_ch_ff, p0_rl_ff, p0_rh_ff;

   always_ff @(posedge clock) begin
      if (reset) p0_vld_ff <= 1'b0;
      else if (en) p0_vld_ff <= start;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_z_ff[0] <= req_z_top_left;
         p0_z_ff[1] <= req_z_bottom_left;
         p0_z_ff[2] <= req_z_bottom_right;
         p0_z_ff[3] <= req_z_top_right;
         p0_cl_ff   <= req_col_lo;
         p0_ch_ff   <= req_col_hi;
         p0_rl_ff   <= req_row_lo;
         p0_rh_ff   <= req_row_hi;
      end
   end

   // level compares and side magnitudes
   logic signed [DATA_W-1:0] za [LANES], zb [LANES], xa [LANES], xb [LANES];
   cell_tag_type             s1_tag_in;
   logic [DATA_W-1:0]        s1_a_in [LANES], s1_c_in [LANES], s1_d_in [LANES];

   always_comb begin
      za[SIDE_L] = p0_z_ff[0]; zb[SIDE_L] = p0_z_ff[1];
      xa[SIDE_L] = p0_rl_ff;   xb[SIDE_L] = p0_rh_ff;
      za[SIDE_R] = p0_z_ff[2]; zb[SIDE_R] = p0_z_ff[3];
      xa[SIDE_R] = p0_rh_ff;   xb[SIDE_R] = p0_rl_ff;
      za[SIDE_U] = p0_z_ff[0]; zb[SIDE_U] = p0_z_ff[3];
      xa[SIDE_U] = p0_cl_ff;   xb[SIDE_U] = p0_ch_ff;
      za[SIDE_D] = p0_z_ff[1]; zb[SIDE_D] = p0_z_ff[2];
      xa[SIDE_D] = p0_cl_ff;   xb[SIDE_D] = p0_ch_ff;
      s1_tag_in.all_ge_next = 1'b1;
      for (int i = 0; i < 4; i++) begin
         s1_tag_in.lt[i] = p0_z_ff[i] < iso_ff;
         s1_tag_in.eq[i] = p0_z_ff[i] == iso_ff;
         s1_tag_in.gt[i] = p0_z_ff[i] > iso_ff;
         if (p0_z_ff[i] < next_ff) s1_tag_in.all_ge_next = 1'b0;
      end
      for (int l = 0; l < LANES; l++) begin
         s1_a_in[l]          = abs_diff(iso_ff, za[l]);
         s1_c_in[l]          = abs_diff(zb[l], za[l]);
         s1_d_in[l]          = abs_diff(xb[l], xa[l]);
         s1_tag_in.up_dir[l] = xb[l] >= xa[l];
      end
      s1_tag_in.fill   = fill_ff;
      s1_tag_in.band   = band_ff;
      s1_tag_in.col_lo = p0_cl_ff;
      s1_tag_in.col_hi = p0_ch_ff;
      s1_tag_in.row_lo = p0_rl_ff;
      s1_tag_in.row_hi = p0_rh_ff;
   end

   logic              s1_vld_ff;
   cell_tag_type      s1_tag_ff;
   logic [DATA_W-1:0] s1_a_ff [LANES], s1_c_ff [LANES], s1_d_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= p0_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff <= s1_tag_in;
         s1_a_ff   <= s1_a_in;
         s1_c_ff   <= s1_c_in;
         s1_d_ff   <= s1_d_in;
      end
   end

   // offset numerator: level distance times side length
   logic              s2_vld_ff;
   cell_tag_type      s2_tag_ff;
   logic [PROD_W-1:0] s2_p_ff [LANES];
   logic [DATA_W-1:0] s2_c_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tag_ff <= s1_tag_ff;
         for (int l = 0; l < LANES; l++) begin
            s2_p_ff[l] <= PROD_W'(s1_a_ff[l]) * PROD_W'(s1_d_ff[l]);
            s2_c_ff[l] <= s1_c_ff[l];
         end
      end
   end

   // divide by the corner value difference
   logic              dv_vld;
   logic [DATA_W-1:0] dv_quo [LANES];
   cell_tag_type      dv_tag;

   gcc_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (s2_vld_ff),
      .in_num  (s2_p_ff),
      .in_den  (s2_c_ff),
      .in_tag  (s2_tag_ff),
      .out_vld (dv_vld),
      .out_quo (dv_quo),
      .out_tag (dv_tag)
   );

   // crossing positions and point selection
   logic [DATA_W-1:0] fx_a [LANES], fx_b [LANES], t_in [LANES];
   logic [3:0]        lt, eq, gt;
   logic              e_a [LANES], e_b [LANES];
   logic              s_l, s_r, s_u, s_d;
   logic              e12, e34, e14, e23, d13, d24, all_below, two;
   logic [3:0]        nl;
   logic [LINE_SLOTS-1:0] lmask;
   logic [POLY_SLOTS-1:0] pmask;
   pt_id_type         pid [POLY_SLOTS];

   always_comb begin
      lt = dv_tag.lt;
      eq = dv_tag.eq;
      gt = dv_tag.gt;
      fx_a[SIDE_L] = dv_tag.row_lo; fx_b[SIDE_L] = dv_tag.row_hi;
      fx_a[SIDE_R] = dv_tag.row_hi; fx_b[SIDE_R] = dv_tag.row_lo;
      fx_a[SIDE_U] = dv_tag.col_lo; fx_b[SIDE_U] = dv_tag.col_hi;
      fx_a[SIDE_D] = dv_tag.col_lo; fx_b[SIDE_D] = dv_tag.col_hi;
      e_a[SIDE_L] = eq[0]; e_b[SIDE_L] = eq[1];
      e_a[SIDE_R] = eq[2]; e_b[SIDE_R] = eq[3];
      e_a[SIDE_U] = eq[0]; e_b[SIDE_U] = eq[3];
      e_a[SIDE_D] = eq[1]; e_b[SIDE_D] = eq[2];
      for (int l = 0; l < LANES; l++) begin
         if (e_a[l])                t_in[l] = fx_a[l];
         else if (e_b[l])           t_in[l] = fx_b[l];
         else if (dv_tag.up_dir[l]) t_in[l] = fx_a[l] + dv_quo[l];
         else                       t_in[l] = fx_a[l] - dv_quo[l];
      end

      // side crossings, edges on the level and diagonals
      s_l = (eq[0] ^ eq[1]) || (lt[0] && gt[1]) || (gt[0] && lt[1]);
      s_r = (eq[2] ^ eq[3]) || (lt[2] && gt[3]) || (gt[2] && lt[3]);
      s_u = (eq[0] ^ eq[3]) || (lt[0] && gt[3]) || (gt[0] && lt[3]);
      s_d = (eq[1] ^ eq[2]) || (lt[1] && gt[2]) || (gt[1] && lt[2]);
      e12 = eq[0] && eq[1];
      e34 = eq[2] && eq[3];
      e14 = eq[0] && eq[3];
      e23 = eq[1] && eq[2];
      d13 = eq[0] && eq[2] && !eq[1] && !eq[3];
      d24 = eq[1] && eq[3] && !eq[0] && !eq[2];
      all_below = &lt;
      nl = 4'(s_l) + 4'(s_r) + 4'(s_u) + 4'(s_d)
         + {2'b0, e12, 1'b0} + {2'b0, e34, 1'b0} + {2'b0, e14, 1'b0}
         + {2'b0, e23, 1'b0} + {2'b0, d13, 1'b0} + {2'b0, d24, 1'b0};
      two = nl == 4'd2;

      lmask = {d24, d24, d13, d13, e23, e23, s_d, e14, e14, s_u,
               e34, e34, s_r, e12, e12, s_l};
      if (nl < 4'd2 || all_below) lmask = '0;

      // fill polygon
      pmask = '0;
      for (int i = 0; i < POLY_SLOTS; i++) pid[i] = PT_TL;
      if (lt == 4'b0000) begin
         if (!(dv_tag.band && dv_tag.all_ge_next)) begin
            pid[0] = PT_TL; pid[1] = PT_TR; pid[2] = PT_BR; pid[3] = PT_BL;
            pmask  = 5'b01111;
         end
      end else if (s_l && s_r && two) begin
         pid[0] = PT_L;
         if (lt[0] && lt[3]) begin pid[1] = PT_BL; pid[2] = PT_BR; end
         else begin pid[1] = PT_TL; pid[2] = PT_TR; end
         pid[3] = PT_R;
         pmask  = 5'b01111;
      end else if (s_u && s_d && two) begin
         pid[0] = PT_U;
         if (lt[0] && lt[1]) begin pid[1] = PT_TR; pid[2] = PT_BR; end
         else begin pid[1] = PT_TL; pid[2] = PT_BL; end
         pid[3] = PT_D;
         pmask  = 5'b01111;
      end else if (s_l && s_d && two) begin
         pid[0] = PT_L;
         if (lt[1]) begin
            pid[1] = PT_TL; pid[2] = PT_TR; pid[3] = PT_BR; pid[4] = PT_D;
            pmask  = 5'b11111;
         end else begin
            pid[1] = PT_BL; pid[2] = PT_D;
            pmask  = 5'b00111;
         end
      end else if (s_r && s_d && two) begin
         pid[0] = PT_R;
         if (lt[2]) begin
            pid[1] = PT_TR; pid[2] = PT_TL; pid[3] = PT_BL; pid[4] = PT_D;
            pmask  = 5'b11111;
         end else begin
            pid[1] = PT_BR; pid[2] = PT_D;
            pmask  = 5'b00111;
         end
      end else if (s_r && s_u && two) begin
         pid[0] = PT_R;
         if (lt[3]) begin
            pid[1] = PT_BR; pid[2] = PT_BL; pid[3] = PT_TL; pid[4] = PT_U;
            pmask  = 5'b11111;
         end else begin
            pid[1] = PT_TR; pid[2] = PT_U;
            pmask  = 5'b00111;
         end
      end else if (s_l && s_u && two) begin
         pid[0] = PT_L;
         if (lt[0]) begin
            pid[1] = PT_BL; pid[2] = PT_BR; pid[3] = PT_TR; pid[4] = PT_U;
            pmask  = 5'b11111;
         end else if (gt[0]) begin
            pid[1] = PT_TL; pid[2] = PT_U;
            pmask  = 5'b00111;
         end
      end else if (e12 || e23 || e34 || e14) begin
         pid[0] = PT_TL; pid[1] = PT_TR; pid[2] = PT_BR; pid[3] = PT_BL;
         if (e12)      pmask = (gt[2] && gt[3]) ? 5'b01111 : 5'b00000;
         else if (e23) pmask = (gt[0] && gt[3]) ? 5'b01111 : 5'b00000;
         else if (e34) pmask = (gt[0] && gt[1]) ? 5'b01111 : 5'b00000;
         else          pmask = (gt[2] && gt[1]) ? 5'b01111 : 5'b00000;
      end else if (eq[0] && eq[2]) begin
         pid[0] = PT_TL;
         if (gt[3] && lt[1]) pid[1] = PT_BL;
         else                pid[1] = PT_TR;
         pid[2] = PT_BR;
         pmask  = 5'b00111;
      end else if (eq[1] && eq[3]) begin
         pid[0] = PT_TR;
         if (gt[0] && lt[2]) pid[1] = PT_TL;
         else                pid[1] = PT_BR;
         pid[2] = PT_BL;
         pmask  = 5'b00111;
      end
      if (!dv_tag.fill || all_below) pmask = '0;
   end

   // output register: walks the pending points of one cell
   logic [SLOTS-1:0]  mask_ff, mask_in;
   pt_id_type         pid_ff [POLY_SLOTS];
   logic [DATA_W-1:0] cl_ff, ch_ff, rl_ff, rh_ff;
   logic [DATA_W-1:0] t_ff [LANES];
   logic [SLOT_W-1:0] sel;
   logic [SLOTS-1:0]  rest;
   logic              can_load;
   pt_id_type         cur;

   always_comb begin
      sel = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel = SLOT_W'(i);
      end
      rest     = mask_ff & ~(SLOTS'(1) << sel);
      can_load = (mask_ff == '0) || (rest == '0);
      stall    = dv_vld && !can_load;
      if (dv_vld && can_load) mask_in = {pmask, lmask};
      else                    mask_in = rest;
      if (sel[SLOT_W-1]) cur = pid_ff[sel[2:0]];
      else               cur = LINE_PT[sel[3:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= '0;
      else mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (dv_vld && can_load) begin
         pid_ff <= pid;
         cl_ff  <= dv_tag.col_lo;
         ch_ff  <= dv_tag.col_hi;
         rl_ff  <= dv_tag.row_lo;
         rh_ff  <= dv_tag.row_hi;
         t_ff   <= t_in;
      end
   end

   // point coordinates by point code
   always_comb begin
      case (cur)
         PT_TL:   begin rsp_point_col = cl_ff;        rsp_point_row = rl_ff;        end
         PT_TR:   begin rsp_point_col = ch_ff;        rsp_point_row = rl_ff;        end
         PT_BR:   begin rsp_point_col = ch_ff;        rsp_point_row = rh_ff;        end
         PT_BL:   begin rsp_point_col = cl_ff;        rsp_point_row = rh_ff;        end
         PT_L:    begin rsp_point_col = cl_ff;        rsp_point_row = t_ff[SIDE_L]; end
         PT_R:    begin rsp_point_col = ch_ff;        rsp_point_row = t_ff[SIDE_R]; end
         PT_U:    begin rsp_point_col = t_ff[SIDE_U]; rsp_point_row = rl_ff;        end
         PT_D:    begin rsp_point_col = t_ff[SIDE_D]; rsp_point_row = rh_ff;        end
         default: begin rsp_point_col = cl_ff;        rsp_point_row = rl_ff;        end
      endcase
   end

   assign rsp_valid      = mask_ff != '0;
   assign rsp_shape_kind = sel[SLOT_W-1];
   assign rsp_shape_end  = sel[SLOT_W-1] ? (rest == '0) : (rest[LINE_SLOTS-1:0] == '0);
   assign rsp_cell_end   = rest == '0;

`ifndef SYNTHESIS
   // a stall is only raised while points of an earlier cell are pending
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy |-> rsp_valid)
      else $error("busy without pending points");

   // the last point of a cell also closes its shape
   a_cell_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_end |-> rsp_shape_end)
      else $error("cell end without shape end");

   // an open contour line continues in the next cycle
   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shape_kind && !rsp_shape_end |=> rsp_valid && !rsp_shape_kind)
      else $error("contour line broken");

   // reset leaves no point pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("point pending after reset");
`endif

endmodule
`default_nettype wire

### rtl/gcc_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_div_pipe
// Four-lane restoring divider, one quotient bit per stage, with the cell
// record riding along. Quotient must fit DATA_W bits (num < den << DATA_W).
// ----------------------------------------------------------------------------
module gcc_div_pipe
   import gcc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_vld,
   input  wire logic [PROD_W-1:0]        in_num [LANES],
   input  wire logic [DATA_W-1:0]        in_den [LANES],
   input  wire cell_tag_type             in_tag,
   output logic                          out_vld,
   output logic [DATA_W-1:0]             out_quo [LANES],
   output cell_tag_type                  out_tag
);

   logic [DATA_W-1:0] rem_ff [DIV_STEPS][LANES];
   logic [DATA_W-1:0] lq_ff  [DIV_STEPS][LANES];
   logic [DATA_W-1:0] den_ff [DIV_STEPS][LANES];
   logic [DIV_STEPS-1:0] vld_ff;
   cell_tag_type      tag_ff [DIV_STEPS];

   logic [DATA_W-1:0] rem_in [DIV_STEPS][LANES];
   logic [DATA_W-1:0] lq_in  [DIV_STEPS][LANES];
   logic [DATA_W-1:0] den_in [DIV_STEPS][LANES];
   logic [DATA_W:0]   part   [DIV_STEPS][LANES];
   logic [DATA_W:0]   diff   [DIV_STEPS][LANES];

   // one trial subtract per stage and lane
   always_comb begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               den_in[s][l] = in_den[l];
               part[s][l]   = {in_num[l][PROD_W-1:DATA_W], in_num[l][DATA_W-1]};
               lq_in[s][l]  = {in_num[l][DATA_W-2:0], 1'b0};
            end else begin
               den_in[s][l] = den_ff[s-1][l];
               part[s][l]   = {rem_ff[s-1][l], lq_ff[s-1][l][DATA_W-1]};
               lq_in[s][l]  = {lq_ff[s-1][l][DATA_W-2:0], 1'b0};
            end
            diff[s][l] = part[s][l] - {1'b0, den_in[s][l]};
            if (part[s][l] >= {1'b0, den_in[s][l]}) begin
               rem_in[s][l]   = diff[s][l][DATA_W-1:0];
               lq_in[s][l][0] = 1'b1;
            end else begin
               rem_in[s][l]   = part[s][l][DATA_W-1:0];
            end
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STEPS-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            tag_ff[s] <= (s == 0) ? in_tag : tag_ff[(s == 0) ? 0 : s-1];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               lq_ff[s][l]  <= lq_in[s][l];
               den_ff[s][l] <= den_in[s][l];
            end
         end
      end
   end

   assign out_vld = vld_ff[DIV_STEPS-1];
   assign out_tag = tag_ff[DIV_STEPS-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) out_quo[l] = lq_ff[DIV_STEPS-1][l];
   end

endmodule
`default_nettype wire
